// ===== hw/rtl/centered_cosine_similarity_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the centered cosine similarity core
// Clocked, reset-qualified implication checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef CENTERED_COSINE_SIMILARITY_CORE_MACROS_SVH
`define CENTERED_COSINE_SIMILARITY_CORE_MACROS_SVH

// same-cycle implication
`define CCS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define CCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== hw/rtl/ccs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_pkg
// Widths, constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package ccs_pkg;

   localparam int RATING_W   = 12;
   localparam int DIFF_W     = RATING_W + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int SQ_W       = 2 * RATING_W;
   localparam int SUM_W      = 48;
   localparam int ROOT_W     = SUM_W / 2;
   localparam int ROOT_EXT_W = SUM_W - 1;
   localparam int SIM_W      = 16;
   localparam int QUO_W      = 15;
   localparam int ONE_Q14    = 16384;

   localparam int SQRT_STEPS = SUM_W / 2;
   localparam int DIV_STEPS  = QUO_W;
   localparam int CNT_W      = $clog2(SQRT_STEPS);

   typedef struct packed {
      logic accept;
      logic sqrt_load;
      logic sqrt_step;
      logic den_load;
      logic div_load;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic last_pending;
      logic den_zero;
      logic out_free;
   } status_type;

endpackage

// ===== hw/rtl/ccs_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_ctrl
// Sequencer: streams pairs, then steps the root, multiply and divide phases.
// ----------------------------------------------------------------------------
module ccs_ctrl
   import ccs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_RUN       = 7'b0000001,
      ST_SQRT_INIT = 7'b0000010,
      ST_SQRT      = 7'b0000100,
      ST_MULT      = 7'b0001000,
      ST_DIV_INIT  = 7'b0010000,
      ST_DIV       = 7'b0100000,
      ST_DONE      = 7'b1000000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // the last pair must finish accumulating before the roots read the sums
   assign req_stall = (state_ff != ST_RUN) || status.last_pending;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_RUN: begin
            cmd.accept = req_valid && !req_stall;
            if (status.last_pending) begin
               state_in = ST_SQRT_INIT;
            end
         end
         ST_SQRT_INIT: begin
            cmd.sqrt_load = 1'b1;
            cnt_in        = '0;
            state_in      = ST_SQRT;
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SQRT_STEPS - 1)) begin
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            cmd.den_load = 1'b1;
            state_in     = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            cmd.div_load = 1'b1;
            cnt_in       = '0;
            state_in     = status.den_zero ? ST_DONE : ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== hw/rtl/ccs_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_datapath
// Centering multipliers, saturating sums, two-lane root, restoring divider.
// ----------------------------------------------------------------------------
module ccs_datapath
   import ccs_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   output status_type              status,
   input  logic [RATING_W-1:0]     req_rating_a,
   input  logic [RATING_W-1:0]     req_rating_b,
   input  logic                    req_first_item,
   input  logic                    req_last_item,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [SIM_W-1:0] rsp_similarity,
   output logic                    rsp_zero_denominator
);

   // ---- stage 1: centering and products ----
   logic [RATING_W-1:0]      mean_a_ff, mean_b_ff;
   logic signed [DIFF_W-1:0] diff_a, diff_b;
   logic signed [PROD_W-1:0] prod_x, prod_a, prod_b;

   logic                     s1_valid_ff, s1_first_ff, s1_last_ff;
   logic                     s1_en_x_ff, s1_en_a_ff, s1_en_b_ff;
   logic signed [PROD_W-1:0] s1_x_ff;
   logic [SQ_W-1:0]          s1_a_ff, s1_b_ff;

   assign diff_a = $signed({1'b0, req_rating_a}) - $signed({1'b0, mean_a_ff});
   assign diff_b = $signed({1'b0, req_rating_b}) - $signed({1'b0, mean_b_ff});
   assign prod_x = diff_a * diff_b;
   assign prod_a = diff_a * diff_a;
   assign prod_b = diff_b * diff_b;

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_a_ff   <= '0;
         mean_b_ff   <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.accept;
         if (cmd.accept && req_first_item) begin
            mean_a_ff <= req_rating_a;
            mean_b_ff <= req_rating_b;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         s1_first_ff <= req_first_item;
         s1_last_ff  <= req_last_item;
         s1_en_a_ff  <= req_rating_a != '0;
         s1_en_b_ff  <= req_rating_b != '0;
         s1_en_x_ff  <= (req_rating_a != '0) && (req_rating_b != '0);
         s1_x_ff     <= prod_x;
         s1_a_ff     <= prod_a[SQ_W-1:0];
         s1_b_ff     <= prod_b[SQ_W-1:0];
      end
   end

   // ---- stage 2: saturating accumulation ----
   logic signed [SUM_W-1:0] cross_sum_ff, cross_sum_in;
   logic [SUM_W-1:0]        sq_sum_a_ff, sq_sum_a_in;
   logic [SUM_W-1:0]        sq_sum_b_ff, sq_sum_b_in;
   logic signed [SUM_W:0]   cross_add;
   logic [SUM_W:0]          sq_add_a, sq_add_b;

   assign cross_add = $signed({cross_sum_ff[SUM_W-1], cross_sum_ff})
                    + $signed({{(SUM_W + 1 - PROD_W){s1_x_ff[PROD_W-1]}}, s1_x_ff});
   assign sq_add_a  = {1'b0, sq_sum_a_ff} + {{(SUM_W + 1 - SQ_W){1'b0}}, s1_a_ff};
   assign sq_add_b  = {1'b0, sq_sum_b_ff} + {{(SUM_W + 1 - SQ_W){1'b0}}, s1_b_ff};

   always_comb begin
      cross_sum_in = cross_sum_ff;
      sq_sum_a_in  = sq_sum_a_ff;
      sq_sum_b_in  = sq_sum_b_ff;
      if (s1_valid_ff) begin
         if (s1_first_ff) begin
            cross_sum_in = '0;
            sq_sum_a_in  = '0;
            sq_sum_b_in  = '0;
         end else begin
            if (s1_en_x_ff) begin
               if (cross_add[SUM_W] != cross_add[SUM_W-1]) begin
                  // overflow: clamp toward the sign of the true sum
                  cross_sum_in = cross_add[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}}
                                                  : {1'b0, {(SUM_W - 1){1'b1}}};
               end else begin
                  cross_sum_in = cross_add[SUM_W-1:0];
               end
            end
            if (s1_en_a_ff) begin
               sq_sum_a_in = sq_add_a[SUM_W] ? '1 : sq_add_a[SUM_W-1:0];
            end
            if (s1_en_b_ff) begin
               sq_sum_b_in = sq_add_b[SUM_W] ? '1 : sq_add_b[SUM_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cross_sum_ff <= '0;
         sq_sum_a_ff  <= '0;
         sq_sum_b_ff  <= '0;
      end else begin
         cross_sum_ff <= cross_sum_in;
         sq_sum_a_ff  <= sq_sum_a_in;
         sq_sum_b_ff  <= sq_sum_b_in;
      end
   end

   // ---- integer square root, both sums side by side, one root bit a cycle ----
   logic [SUM_W-1:0]      rad_a_ff, rad_b_ff;
   logic [ROOT_EXT_W-1:0] root_a_ff, root_b_ff, bit_ff;
   logic [ROOT_EXT_W-1:0] trial_a, trial_b;
   logic                  ge_a, ge_b;

   // root bits always sit above the trial bit, so OR equals the sum
   assign trial_a = root_a_ff | bit_ff;
   assign trial_b = root_b_ff | bit_ff;
   assign ge_a    = rad_a_ff >= {1'b0, trial_a};
   assign ge_b    = rad_b_ff >= {1'b0, trial_b};

   always_ff @(posedge clock) begin
      if (cmd.sqrt_load) begin
         rad_a_ff  <= sq_sum_a_ff;
         rad_b_ff  <= sq_sum_b_ff;
         root_a_ff <= '0;
         root_b_ff <= '0;
         bit_ff    <= {1'b1, {(ROOT_EXT_W - 1){1'b0}}};
      end else if (cmd.sqrt_step) begin
         if (ge_a) begin
            rad_a_ff  <= rad_a_ff - {1'b0, trial_a};
            root_a_ff <= (root_a_ff >> 1) | bit_ff;
         end else begin
            root_a_ff <= root_a_ff >> 1;
         end
         if (ge_b) begin
            rad_b_ff  <= rad_b_ff - {1'b0, trial_b};
            root_b_ff <= (root_b_ff >> 1) | bit_ff;
         end else begin
            root_b_ff <= root_b_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   // ---- denominator and magnitude of the cross sum ----
   logic [SUM_W-1:0] den_ff, mag_ff;
   logic             neg_ff;

   always_ff @(posedge clock) begin
      if (cmd.den_load) begin
         den_ff <= root_a_ff[ROOT_W-1:0] * root_b_ff[ROOT_W-1:0];
         neg_ff <= cross_sum_ff[SUM_W-1];
         mag_ff <= cross_sum_ff[SUM_W-1] ? SUM_W'(-cross_sum_ff) : SUM_W'(cross_sum_ff);
      end
   end

   // ---- restoring divide: (mag << 14) / den, one quotient bit a cycle ----
   logic [SUM_W:0]   rem_ff, rem_sub;
   logic [QUO_W-1:0] quo_ff;
   logic             sat_ff;
   logic             rem_ge;

   assign rem_ge  = rem_ff >= {1'b0, den_ff};
   assign rem_sub = rem_ge ? rem_ff - {1'b0, den_ff} : rem_ff;

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         rem_ff <= {1'b0, mag_ff};
         quo_ff <= '0;
         // quotient of two or more: beyond what the steps resolve, clamps anyway
         sat_ff <= {1'b0, mag_ff} >= {den_ff, 1'b0};
      end else if (cmd.div_step) begin
         rem_ff <= {rem_sub[SUM_W-1:0], 1'b0};
         quo_ff <= {quo_ff[QUO_W-2:0], rem_ge};
      end
   end

   // ---- output register ----
   logic                    rsp_valid_ff;
   logic signed [SIM_W-1:0] rsp_sim_ff;
   logic                    rsp_zero_ff;
   logic [SIM_W-1:0]        q_clamp;
   logic signed [SIM_W-1:0] sim_value;

   always_comb begin
      if (sat_ff || ({1'b0, quo_ff} > SIM_W'(ONE_Q14))) begin
         q_clamp = SIM_W'(ONE_Q14);
      end else begin
         q_clamp = {1'b0, quo_ff};
      end
      sim_value = neg_ff ? -$signed(q_clamp) : $signed(q_clamp);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_zero_ff <= status.den_zero;
         rsp_sim_ff  <= status.den_zero ? '0 : sim_value;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_similarity       = rsp_sim_ff;
   assign rsp_zero_denominator = rsp_zero_ff;

   assign status.last_pending = s1_valid_ff && s1_last_ff;
   assign status.den_zero     = den_ff == '0;
   assign status.out_free     = !rsp_valid_ff || !rsp_stall;

endmodule

// ===== hw/rtl/centered_cosine_similarity_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// centered_cosine_similarity_core
// Streaming centered cosine similarity of two Q4.8 rating vectors.
// ----------------------------------------------------------------------------
// A vector starts with a pair flagged first_item that carries the two means;
// every later pair is taken one per cycle and accumulated through a two-stage
// multiply/accumulate pipe (zero ratings are skipped as unrated). After the
// pair flagged last_item is taken, the input stalls while the result is
// formed: accumulation finishes, then the two-lane square root runs (a
// load, then one root bit per cycle for 24 bits), then the root product
// is formed, then the restoring divider runs (a load, then one quotient
// bit per cycle for 15 bits), and finally the output register is loaded.
// That last step is held off, and the stall grows, while an earlier result
// is still stalled in the output register. A zero denominator skips the
// divider steps. The result is signed Q1.14 clamped to plus or minus one
// and waits in an output register until transferred; the next vector can
// stream in meanwhile.
// ----------------------------------------------------------------------------
module centered_cosine_similarity_core
   import ccs_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [RATING_W-1:0]     req_rating_a,
   input  logic [RATING_W-1:0]     req_rating_b,
   input  logic                    req_first_item,
   input  logic                    req_last_item,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [SIM_W-1:0] rsp_similarity,
   output logic                    rsp_zero_denominator
);

   cmd_type    cmd;
   status_type status;

   ccs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ccs_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_rating_a         (req_rating_a),
      .req_rating_b         (req_rating_b),
      .req_first_item       (req_first_item),
      .req_last_item        (req_last_item),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_similarity       (rsp_similarity),
      .rsp_zero_denominator (rsp_zero_denominator)
   );

endmodule

// ===== hw/rtl/ccs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccs_checker
// Port-level checks on the similarity core, bound to the top level.
// ----------------------------------------------------------------------------
`include "centered_cosine_similarity_core_macros.svh"

module ccs_checker
   import ccs_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_stall,
   input logic                    req_last_item,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic signed [SIM_W-1:0] rsp_similarity,
   input logic                    rsp_zero_denominator
);

   logic last_xfer;
   logic sim_in_range;

   assign last_xfer    = req_valid && !req_stall && req_last_item;
   assign sim_in_range = (rsp_similarity <= SIM_W'(ONE_Q14))
                      && (rsp_similarity >= -$signed(SIM_W'(ONE_Q14)));

   // a held result keeps its payload
   `CCS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_similarity) && $stable(rsp_zero_denominator))

   // a zero denominator always comes with a zero similarity
   `CCS_ASSERT_IMPLY(a_zero_den_value, clock, reset, rsp_valid && rsp_zero_denominator,
      rsp_similarity == '0)

   // similarity never leaves plus or minus one
   `CCS_ASSERT_IMPLY(a_sim_range, clock, reset, rsp_valid, sim_in_range)

   // the end of a vector blocks input while the result is formed
   `CCS_ASSERT_NEXT(a_last_stalls, clock, reset, last_xfer, req_stall)

endmodule

bind centered_cosine_similarity_core ccs_checker u_checker (.*);
